// File: src/sdbs_pkg.sv
// Shared types and constants of the soft disk brush stamp.
// Used by every module of the block but sdbs_texmem; depends on nothing.
package sdbs_pkg;

    localparam int DEF_MAX_SIDE   = 256;
    localparam int DEF_MAX_RADIUS = 40;

    localparam int DATA_W  = 17;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 3;
    localparam int ROOT_W  = 26;
    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 17;

    localparam logic [DATA_W-1:0]  Q_ONE     = 17'h10000;
    localparam logic [DATA_W-1:0]  Q_HALF    = 17'h08000;
    localparam logic [DATA_W-1:0]  MIN_SPAN  = 17'd66;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_PAINT = 2'd2;

    localparam logic [IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_RADIUS     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_HARDNESS   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PAINT      = 3'd4;
    localparam logic [IDX_W-1:0] CFG_MASK       = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RDWAIT,
        S_BOUNDS,
        S_EVAL,
        S_SQRT,
        S_DIV_D,
        S_DIV_F,
        S_MULT,
        S_WRITE,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic wr_direct;
        logic rd_direct;
        logic cap_read;
        logic bounds;
        logic advance;
        logic sqrt_start;
        logic div_start;
        logic div_fall;
        logic weight_full;
        logic weight_fall;
        logic mult;
        logic write_back;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       have_map;
        logic       inside_pos;
        logic       in_disk;
        logic       last_texel;
        logic       sqrt_done;
        logic       div_done;
        logic       d_lt_hard;
    } dp_sts_t;

endpackage

// File: src/sdbs_texmem.sv
// Texel store: single port memory with registered read data.
// Depends on nothing; sized by its parameters.
module sdbs_texmem #(
    parameter int AW = 16,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sdbs_divu.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sdbs_pkg for its widths.
module sdbs_divu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sdbs_pkg::DIV_NUM_W-1:0] num,
    input  logic [sdbs_pkg::DIV_DEN_W-1:0] den,
    output logic                           busy,
    output logic [sdbs_pkg::DIV_NUM_W-1:0] quot
);

    localparam int NW = sdbs_pkg::DIV_NUM_W;
    localparam int DNW = sdbs_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  num_reg, num_next;
    logic [DNW-1:0] rem_reg, rem_next;
    logic [DNW-1:0] den_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DNW:0]   rem_sh;
    logic           qbit;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NW-1]};
        qbit = rem_sh >= {1'b0, den_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            num_next = num;
            rem_next = '0;
            cnt_next = CW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            // quotient bits shift in where the numerator shifts out
            num_next = {num_reg[NW-2:0], qbit};
            rem_next = qbit ? DNW'(rem_sh - {1'b0, den_reg}) : DNW'(rem_sh);
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = num_reg;

endmodule

// File: src/sdbs_datapath.sv
// Datapath: config registers, item registers, stamp scan, square root,
// weight, blend and texel store. Depends on sdbs_pkg, sdbs_texmem, sdbs_divu.
module sdbs_datapath #(
    parameter int MAX_SIDE   = sdbs_pkg::DEF_MAX_SIDE,
    parameter int MAX_RADIUS = sdbs_pkg::DEF_MAX_RADIUS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sdbs_pkg::IDX_W-1:0]       cfg_index,
    input  logic [sdbs_pkg::CFG_W-1:0]       cfg_data,
    input  logic [1:0]                       func,
    input  logic [7:0]                       col,
    input  logic [7:0]                       row,
    input  logic [sdbs_pkg::DATA_W-1:0]      texel_in,
    input  logic [sdbs_pkg::DATA_W-1:0]      center_u,
    input  logic [sdbs_pkg::DATA_W-1:0]      center_t,
    input  sdbs_pkg::dp_cmd_t                cmd,
    output sdbs_pkg::dp_sts_t                sts,
    output logic [sdbs_pkg::DATA_W-1:0]      texel_out,
    output logic [sdbs_pkg::COUNT_W-1:0]     touched_count,
    output logic                             accepted
);

    localparam int DW = sdbs_pkg::DATA_W;
    localparam int XW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int AW = 2 * XW;
    localparam int RAD_CAP = MAX_RADIUS * 16 > 1023 ? 1023 : MAX_RADIUS * 16;
    localparam int RTW = sdbs_pkg::ROOT_W;
    localparam int NSW = 2 * RTW;
    localparam int SCW = $clog2(RTW + 1);

    // configuration
    logic [8:0]    map_w_reg, map_h_reg;
    logic [9:0]    radius_reg;
    logic [DW-1:0] hard_cfg_reg, paint_cfg_reg;
    logic          mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg <= '0;
            map_h_reg <= '0;
            radius_reg <= 10'd16;
            hard_cfg_reg <= '0;
            paint_cfg_reg <= sdbs_pkg::Q_ONE;
            mask_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdbs_pkg::CFG_MAP_WIDTH:  map_w_reg <= cfg_data[8:0];
                sdbs_pkg::CFG_MAP_HEIGHT: map_h_reg <= cfg_data[8:0];
                sdbs_pkg::CFG_RADIUS:     radius_reg <= cfg_data[9:0];
                sdbs_pkg::CFG_HARDNESS:   hard_cfg_reg <= cfg_data;
                sdbs_pkg::CFG_PAINT:      paint_cfg_reg <= cfg_data;
                sdbs_pkg::CFG_MASK:       mask_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    function automatic logic [DW-1:0] sat_one(input logic [DW-1:0] v);
        return (v > sdbs_pkg::Q_ONE) ? sdbs_pkg::Q_ONE : v;
    endfunction

    logic [SW-1:0] w_side, h_side;
    logic [9:0]    rad;
    logic [DW-1:0] hard, paint, span;

    always_comb
    begin
        w_side = (32'(map_w_reg) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(map_w_reg);
        h_side = (32'(map_h_reg) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(map_h_reg);
        if (radius_reg < 10'd16)
            rad = 10'd16;
        else if (32'(radius_reg) > 32'(RAD_CAP))
            rad = 10'(RAD_CAP);
        else
            rad = radius_reg;
        hard = sat_one(hard_cfg_reg);
        paint = sat_one(paint_cfg_reg);
        span = DW'(sdbs_pkg::Q_ONE - hard);
        if (span < sdbs_pkg::MIN_SPAN)
            span = sdbs_pkg::MIN_SPAN;
    end

    // item registers
    logic [1:0]    func_reg;
    logic [7:0]    col_reg, row_reg;
    logic [DW-1:0] tin_reg, cu_reg, ct_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            col_reg <= col;
            row_reg <= row;
            tin_reg <= sat_one(texel_in);
            cu_reg <= sat_one(center_u);
            ct_reg <= sat_one(center_t);
        end
    end

    logic have_map, inside_pos;
    assign have_map = (w_side != '0) && (h_side != '0);
    assign inside_pos = have_map && (32'(col_reg) < 32'(w_side)) && (32'(row_reg) < 32'(h_side));

    // stamp geometry
    logic [XW-1:0] cx_reg, cy_reg, x_reg, y_reg, x0_reg, x1_reg, y1_reg;
    logic [19:0]   rad2_reg;
    logic signed [31:0] cx_i, cy_i, r_i, lo_x, hi_x, lo_y, hi_y, dx_i, dy_i;
    logic signed [7:0]  dx8, dy8;
    logic signed [15:0] dxx, dyy;
    logic [13:0]   dsum;
    logic [21:0]   d2;
    logic          in_disk, last_texel;

    always_comb
    begin
        cx_i = 32'(cx_reg);
        cy_i = 32'(cy_reg);
        r_i = 32'((32'(rad) + 32'd15) >> 4);
        lo_x = cx_i - r_i;
        if (lo_x < 0)
            lo_x = 0;
        hi_x = cx_i + r_i;
        if (hi_x > 32'(w_side) - 1)
            hi_x = 32'(w_side) - 1;
        lo_y = cy_i - r_i;
        if (lo_y < 0)
            lo_y = 0;
        hi_y = cy_i + r_i;
        if (hi_y > 32'(h_side) - 1)
            hi_y = 32'(h_side) - 1;
        dx_i = 32'(x_reg) - cx_i;
        dy_i = 32'(y_reg) - cy_i;
        dx8 = 8'(dx_i);
        dy8 = 8'(dy_i);
        dxx = dx8 * dx8;
        dyy = dy8 * dy8;
        dsum = 14'(dxx) + 14'(dyy);
        d2 = {dsum, 8'b0};
        in_disk = d2 <= {2'b0, rad2_reg};
        last_texel = (x_reg == x1_reg) && (y_reg == y1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= XW'((32'(cu_reg) * (32'(w_side) - 32'd1) + 32'(sdbs_pkg::Q_HALF)) >> 16);
            cy_reg <= XW'((32'(ct_reg) * (32'(h_side) - 32'd1) + 32'(sdbs_pkg::Q_HALF)) >> 16);
        end
        if (cmd.bounds)
        begin
            x0_reg <= XW'(lo_x);
            x1_reg <= XW'(hi_x);
            y1_reg <= XW'(hi_y);
            x_reg <= XW'(lo_x);
            y_reg <= XW'(lo_y);
            rad2_reg <= rad * rad;
        end
        else if (cmd.advance)
        begin
            if (x_reg == x1_reg)
            begin
                x_reg <= x0_reg;
                y_reg <= y_reg + 1'b1;
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    // bit-pair square root of d2 * 2^32
    logic [NSW-1:0] sq_n_reg;
    logic [RTW+1:0] sq_rem_reg;
    logic [RTW-1:0] sq_root_reg;
    logic [SCW-1:0] sq_cnt_reg;
    logic [RTW+3:0] sq_sh, sq_trial;
    logic           sq_take;

    always_comb
    begin
        sq_sh = {sq_rem_reg, sq_n_reg[NSW-1 -: 2]};
        sq_trial = {2'b0, sq_root_reg, 2'b01};
        sq_take = sq_sh >= sq_trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_cnt_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_cnt_reg <= SCW'(RTW);
        end
        else if (sq_cnt_reg != '0)
        begin
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_n_reg <= {d2[19:0], 32'b0};
            sq_rem_reg <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_cnt_reg != '0)
        begin
            sq_n_reg <= {sq_n_reg[NSW-3:0], 2'b00};
            sq_rem_reg <= sq_take ? (RTW+2)'(sq_sh - sq_trial) : (RTW+2)'(sq_sh);
            sq_root_reg <= {sq_root_reg[RTW-2:0], sq_take};
        end
    end

    // shared divider: distance, then edge falloff
    logic [sdbs_pkg::DIV_NUM_W-1:0] div_num, div_quot;
    logic [sdbs_pkg::DIV_DEN_W-1:0] div_den;
    logic                           div_busy;
    logic [DW-1:0]                  d_q;

    always_comb
    begin
        d_q = (div_quot > 33'(sdbs_pkg::Q_ONE)) ? sdbs_pkg::Q_ONE : div_quot[DW-1:0];
        if (cmd.div_fall)
        begin
            div_num = {DW'(d_q - hard), 16'b0};
            div_den = span;
        end
        else
        begin
            div_num = {7'b0, sq_root_reg};
            div_den = {7'b0, rad};
        end
    end

    sdbs_divu u_divu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // weight, product, blend
    logic [DW-1:0]      w_reg;
    logic signed [35:0] prod_reg;
    logic [DW-1:0]      mem_rdata;
    logic signed [17:0] diff;
    logic [35:0]        mag;
    logic [19:0]        step;
    logic signed [31:0] blend_i;
    logic [DW-1:0]      blend_v;

    always_comb
    begin
        diff = $signed({1'b0, paint}) - $signed({1'b0, mem_rdata});
        mag = prod_reg < 0 ? 36'(-prod_reg) : 36'(prod_reg);
        step = 20'((mag + 36'(sdbs_pkg::Q_HALF)) >> 16);
        if (prod_reg < 0)
            blend_i = 32'(mem_rdata) - 32'(step);
        else
            blend_i = 32'(mem_rdata) + 32'(step);
        if (blend_i < 0)
            blend_v = '0;
        else if (blend_i > 32'(sdbs_pkg::Q_ONE))
            blend_v = sdbs_pkg::Q_ONE;
        else
            blend_v = DW'(blend_i);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.weight_full)
        begin
            w_reg <= sdbs_pkg::Q_ONE;
        end
        else if (cmd.weight_fall)
        begin
            w_reg <= (div_quot >= 33'(sdbs_pkg::Q_ONE)) ? '0
                   : DW'(sdbs_pkg::Q_ONE - div_quot[DW-1:0]);
        end
        if (cmd.mult)
        begin
            prod_reg <= 36'(diff * $signed({1'b0, w_reg}));
        end
    end

    // texel store
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr, pos_addr, scan_addr;
    logic [DW-1:0] mem_wdata;
    logic          wb_we;

    always_comb
    begin
        pos_addr = {XW'(32'(row_reg)), XW'(32'(col_reg))};
        scan_addr = {y_reg, x_reg};
        wb_we = mask_reg ? (w_reg > sdbs_pkg::Q_HALF) : 1'b1;
        mem_we = cmd.wr_direct || (cmd.write_back && wb_we);
        mem_re = cmd.rd_direct || cmd.sqrt_start;
        mem_addr = (cmd.wr_direct || cmd.rd_direct) ? pos_addr : scan_addr;
        if (cmd.wr_direct)
            mem_wdata = tin_reg;
        else if (mask_reg)
            mem_wdata = paint;
        else
            mem_wdata = blend_v;
    end

    sdbs_texmem #(
        .AW (AW),
        .DW (DW)
    ) u_texmem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // result
    logic [sdbs_pkg::COUNT_W-1:0] count_reg, out_count_reg;
    logic [DW-1:0]                rd_val_reg, out_texel_reg;
    logic                         acc_reg, out_acc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            count_reg <= '0;
            rd_val_reg <= '0;
        end
        else
        begin
            if (cmd.write_back && count_reg < sdbs_pkg::COUNT_MAX)
                count_reg <= count_reg + 1'b1;
            if (cmd.cap_read)
                rd_val_reg <= mem_rdata;
        end
        if (cmd.load)
        begin
            case (func_reg)
                sdbs_pkg::FUNC_WRITE: acc_reg <= inside_pos;
                sdbs_pkg::FUNC_READ:  acc_reg <= inside_pos;
                sdbs_pkg::FUNC_PAINT: acc_reg <= have_map;
                default:              acc_reg <= 1'b0;
            endcase
        end
        if (cmd.out_load)
        begin
            out_texel_reg <= rd_val_reg;
            out_count_reg <= count_reg;
            out_acc_reg <= acc_reg;
        end
    end

    assign texel_out = out_texel_reg;
    assign touched_count = out_count_reg;
    assign accepted = out_acc_reg;

    always_comb
    begin
        sts.func = func_reg;
        sts.have_map = have_map;
        sts.inside_pos = inside_pos;
        sts.in_disk = in_disk;
        sts.last_texel = last_texel;
        sts.sqrt_done = sq_cnt_reg == '0;
        sts.div_done = !div_busy;
        sts.d_lt_hard = d_q < hard;
    end

endmodule

// File: src/sdbs_ctrl.sv
// Controller: state machine sequencing one item through the datapath.
// Depends on sdbs_pkg for the state type and command and status structs.
module sdbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sdbs_pkg::dp_sts_t sts,
    output sdbs_pkg::dp_cmd_t cmd
);

    sdbs_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdbs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            sdbs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = sdbs_pkg::S_LOAD;
                end
            end
            sdbs_pkg::S_LOAD:
            begin
                cmd.load = 1'b1;
                state_next = sdbs_pkg::S_FINISH;
                case (sts.func)
                    sdbs_pkg::FUNC_WRITE:
                        cmd.wr_direct = sts.inside_pos;
                    sdbs_pkg::FUNC_READ:
                    begin
                        if (sts.inside_pos)
                        begin
                            cmd.rd_direct = 1'b1;
                            state_next = sdbs_pkg::S_RDWAIT;
                        end
                    end
                    sdbs_pkg::FUNC_PAINT:
                    begin
                        if (sts.have_map)
                            state_next = sdbs_pkg::S_BOUNDS;
                    end
                    default: ;
                endcase
            end
            sdbs_pkg::S_RDWAIT:
            begin
                cmd.cap_read = 1'b1;
                state_next = sdbs_pkg::S_FINISH;
            end
            sdbs_pkg::S_BOUNDS:
            begin
                cmd.bounds = 1'b1;
                state_next = sdbs_pkg::S_EVAL;
            end
            sdbs_pkg::S_EVAL:
            begin
                if (sts.in_disk)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next = sdbs_pkg::S_SQRT;
                end
                else if (sts.last_texel)
                begin
                    state_next = sdbs_pkg::S_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            sdbs_pkg::S_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = sdbs_pkg::S_DIV_D;
                end
            end
            sdbs_pkg::S_DIV_D:
            begin
                if (sts.div_done)
                begin
                    if (sts.d_lt_hard)
                    begin
                        cmd.weight_full = 1'b1;
                        state_next = sdbs_pkg::S_MULT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_fall = 1'b1;
                        state_next = sdbs_pkg::S_DIV_F;
                    end
                end
            end
            sdbs_pkg::S_DIV_F:
            begin
                if (sts.div_done)
                begin
                    cmd.weight_fall = 1'b1;
                    state_next = sdbs_pkg::S_MULT;
                end
            end
            sdbs_pkg::S_MULT:
            begin
                cmd.mult = 1'b1;
                state_next = sdbs_pkg::S_WRITE;
            end
            sdbs_pkg::S_WRITE:
            begin
                cmd.write_back = 1'b1;
                if (sts.last_texel)
                    state_next = sdbs_pkg::S_FINISH;
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = sdbs_pkg::S_EVAL;
                end
            end
            sdbs_pkg::S_FINISH:
            begin
                // hold until the output word is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = sdbs_pkg::S_IDLE;
                end
            end
            default:
                state_next = sdbs_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending word");
    a_rose_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == sdbs_pkg::S_FINISH)
        else $error("output valid raised outside finish");
    a_sqrt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |=> !sts.sqrt_done)
        else $error("square root did not start");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider did not start");
`endif

endmodule

// File: src/soft_disk_brush_stamp.sv
// Soft disk brush stamp on a gray Q1.16 texel map.
// Depends on sdbs_pkg, sdbs_ctrl and sdbs_datapath.
//
// Input channel (in_valid/in_ready) carries one word per item: func 0 writes
// texel_in at (col, row), func 1 reads it back, func 2 paints a stamp centered
// at (center_u, center_t). Output channel (out_valid/out_ready) returns one
// word per item: texel_out, touched_count, accepted.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// A write goes from accept through S_LOAD and S_FINISH, a read through S_LOAD,
// S_RDWAIT and S_FINISH; out_valid is registered after S_FINISH. A paint
// item passes S_LOAD and S_BOUNDS, then S_EVAL for each texel of the clipped
// square; a texel inside the disk adds the one-bit-per-cycle square root (26
// steps) and the shared 33-step divider, run once at full weight and twice
// for soft texels. After S_FINISH the controller returns to S_IDLE, where it takes the next word.
// One item is in work at a time; the next is accepted while the previous
// result still waits on the output register.
// Reset clears the controller and the configuration registers to their
// defaults; the texel map is not cleared and must be written before it is read.
// When the receiver stalls, the finished result holds and the block waits
// after its next item until the output word is taken.
module soft_disk_brush_stamp #(
    parameter int MAX_SIDE   = sdbs_pkg::DEF_MAX_SIDE,
    parameter int MAX_RADIUS = sdbs_pkg::DEF_MAX_RADIUS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [sdbs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sdbs_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [7:0]                   col,
    input  logic [7:0]                   row,
    input  logic [sdbs_pkg::DATA_W-1:0]  texel_in,
    input  logic [sdbs_pkg::DATA_W-1:0]  center_u,
    input  logic [sdbs_pkg::DATA_W-1:0]  center_t,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sdbs_pkg::DATA_W-1:0]  texel_out,
    output logic [sdbs_pkg::COUNT_W-1:0] touched_count,
    output logic                         accepted
);

    sdbs_pkg::dp_cmd_t cmd;
    sdbs_pkg::dp_sts_t sts;

    sdbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sdbs_datapath #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .col           (col),
        .row           (row),
        .texel_in      (texel_in),
        .center_u      (center_u),
        .center_t      (center_t),
        .cmd           (cmd),
        .sts           (sts),
        .texel_out     (texel_out),
        .touched_count (touched_count),
        .accepted      (accepted)
    );

endmodule
